@@ rtl/light_to_brightness_slew_defines.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef LIGHT_TO_BRIGHTNESS_SLEW_DEFINES_SVH
`define LIGHT_TO_BRIGHTNESS_SLEW_DEFINES_SVH

// antecedent now, consequent in the next cycle
`define LTBS_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("ltbs assertion failed");

// antecedent and consequent in the same cycle
`define LTBS_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("ltbs assertion failed");

`endif

@@ rtl/ltbs_pkg.sv @@
// shared types and constants for the light to brightness slew block
// no dependencies
package ltbs_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int TIME_W    = 16;
    localparam int LEVEL_W   = 8;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 8'd255;
    localparam int HALF_W    = 7;
    localparam logic [HALF_W-1:0]  HALF_LEVEL = HALF_W'(MAX_LEVEL / 2);

    // numerator of the mapping division: half level times a sample difference
    localparam int NUM_W     = HALF_W + SAMPLE_W;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam logic [SAMPLE_W-1:0] DAY_RESET   = 10'd800;
    localparam logic [SAMPLE_W-1:0] ROOM_RESET  = 10'd400;
    localparam logic [SAMPLE_W-1:0] NIGHT_RESET = 10'd100;
    localparam logic [TIME_W-1:0]   INTV_RESET  = 16'd100;

    typedef enum logic [1:0] {
        REG_DAY   = 2'd0,
        REG_ROOM  = 2'd1,
        REG_NIGHT = 2'd2,
        REG_INTV  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_STEP
    } t_state;

endpackage

@@ rtl/light_to_brightness_slew.sv @@
// sequence per word: accept, S_CHECK, then S_DIV when the map needs a division,
// then S_STEP, which commits once the output register is free
// one word at a time: o_stall stays high until S_STEP commits; the restoring divider
// (one quotient bit a cycle through a shared subtract/compare) does the division
// reset (synchronous, active low) restores register defaults, clears
// last update time, target and brightness, and empties the output register
module light_to_brightness_slew
    import ltbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [TIME_W-1:0]   i_timestamp,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_sample_ready,
    // result words
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_updated,
    output logic [LEVEL_W-1:0]  o_target_level,
    output logic [LEVEL_W-1:0]  o_brightness,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // sequencer state
    t_state r_state, n_state;

    // configuration registers
    logic [SAMPLE_W-1:0] r_day, r_room, r_night;
    logic [TIME_W-1:0]   r_intv;

    // kept state of the controller
    logic [TIME_W-1:0]   r_last, n_last;
    logic [LEVEL_W-1:0]  r_target, n_target;
    logic [LEVEL_W-1:0]  r_bright, n_bright;

    // captured input word
    logic [TIME_W-1:0]   r_ts;
    logic [SAMPLE_W-1:0] r_s;
    logic                r_rdy;

    // working registers: update flag, base level, divider operands
    logic                r_upd, n_upd;
    logic [LEVEL_W-1:0]  r_base, n_base;
    logic [NUM_W-1:0]    r_nq, n_nq;   // numerator shifts out, quotient shifts in
    logic [SAMPLE_W-1:0] r_rem, n_rem;
    logic [SAMPLE_W-1:0] r_den, n_den;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // output register
    logic                r_ovalid, n_ovalid;
    logic                r_oupd;
    logic [LEVEL_W-1:0]  r_otgt, r_obr;
    logic                out_load;

    logic                in_acc;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    // datapath helpers
    logic [TIME_W-1:0]   elapsed;
    logic                do_upd;
    logic [SAMPLE_W-1:0] diff_lo;
    logic [SAMPLE_W:0]   rem_sh;
    logic                rem_ge;
    logic [LEVEL_W-1:0]  new_tgt;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_DAY:   prdata = DATA_W'(r_day);
            REG_ROOM:  prdata = DATA_W'(r_room);
            REG_NIGHT: prdata = DATA_W'(r_night);
            REG_INTV:  prdata = DATA_W'(r_intv);
            default:   prdata = '0;
        endcase
    end

    // elapsed time with 16-bit wrap
    assign elapsed = r_ts - r_last;
    assign do_upd  = r_rdy && (elapsed >= r_intv);

    // one restoring divider step: the shared subtract/compare unit
    assign rem_sh = {r_rem, r_nq[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});

    // quotient never exceeds the half level, so the low bits carry it
    assign new_tgt = r_base + LEVEL_W'(r_nq[HALF_W-1:0]);

    // sequencer, next state and datapath
    always_comb begin
        n_state  = r_state;
        n_last   = r_last;
        n_target = r_target;
        n_bright = r_bright;
        n_upd    = r_upd;
        n_base   = r_base;
        n_nq     = r_nq;
        n_rem    = r_rem;
        n_den    = r_den;
        n_cnt    = r_cnt;
        diff_lo  = '0;
        out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_upd = do_upd;
                n_rem = '0;
                n_nq  = '0;
                n_cnt = CNT_W'(NUM_W - 1);
                n_state = S_STEP;
                if (do_upd) begin
                    n_last = r_last + r_intv;
                    // branches in priority order, first match wins
                    priority if (r_s > r_day) begin
                        n_base = MAX_LEVEL;
                    end else if (r_s > r_room) begin
                        diff_lo = r_s - r_room;
                        n_base  = LEVEL_W'(HALF_LEVEL);
                        n_den   = r_day - r_room;
                        n_nq    = NUM_W'(HALF_LEVEL) * NUM_W'(diff_lo);
                        n_state = S_DIV;
                    end else if (r_s > r_night) begin
                        diff_lo = r_s - r_night;
                        n_base  = '0;
                        n_den   = r_room - r_night;
                        n_nq    = NUM_W'(HALF_LEVEL) * NUM_W'(diff_lo);
                        n_state = S_DIV;
                    end else if (r_s > (r_night >> 1)) begin
                        n_base = '0;
                    end else begin
                        // reading too dark to be real: sensor taken as invalid
                        n_base = MAX_LEVEL;
                    end
                end
            end
            S_DIV: begin
                n_rem = rem_ge ? SAMPLE_W'(rem_sh - {1'b0, r_den}) : rem_sh[SAMPLE_W-1:0];
                n_nq  = {r_nq[NUM_W-2:0], rem_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                // commit once the output register is free
                if (!r_ovalid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_upd) begin
                        n_target = new_tgt;
                        if (new_tgt > r_bright) begin
                            n_bright = r_bright + 1'b1;
                        end else if (new_tgt < r_bright) begin
                            n_bright = r_bright - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        priority if (out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and kept state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day    <= DAY_RESET;
            r_room   <= ROOM_RESET;
            r_night  <= NIGHT_RESET;
            r_intv   <= INTV_RESET;
            r_last   <= '0;
            r_target <= '0;
            r_bright <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_upd    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_DAY:   r_day   <= pwdata[SAMPLE_W-1:0];
                    REG_ROOM:  r_room  <= pwdata[SAMPLE_W-1:0];
                    REG_NIGHT: r_night <= pwdata[SAMPLE_W-1:0];
                    REG_INTV:  r_intv  <= pwdata[TIME_W-1:0];
                    default:   r_intv  <= r_intv;
                endcase
            end
            r_last   <= n_last;
            r_target <= n_target;
            r_bright <= n_bright;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_upd    <= n_upd;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ts  <= i_timestamp;
            r_s   <= i_sample;
            r_rdy <= i_sample_ready;
        end
        r_base <= n_base;
        r_nq   <= n_nq;
        r_rem  <= n_rem;
        r_den  <= n_den;
        if (out_load) begin
            r_oupd <= r_upd;
            r_otgt <= n_target;
            r_obr  <= n_bright;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_updated      = r_oupd;
    assign o_target_level = r_otgt;
    assign o_brightness   = r_obr;

endmodule

@@ rtl/ltbs_checker.sv @@
// port-level checks for the light to brightness slew block, bound to the top
// depends on ltbs_pkg and light_to_brightness_slew_defines.svh
`include "light_to_brightness_slew_defines.svh"

module ltbs_checker
    import ltbs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic                o_updated,
    input logic [LEVEL_W-1:0]  o_target_level,
    input logic [LEVEL_W-1:0]  o_brightness,
    input logic                psel,
    input logic                penable,
    input logic                pready
);

    // a stalled result word holds
    `LTBS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_updated) && $stable(o_target_level) && $stable(o_brightness))

    // the block is busy right after taking a word
    `LTBS_ASSERT_NEXT(a_busy_after_acc, i_clk, !i_rst_n, i_valid && !o_stall, o_stall)

    // reset empties the output register
    `LTBS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid)

    // register access never waits
    `LTBS_ASSERT_NOW(a_no_wait, i_clk, !i_rst_n, psel && penable, pready)

endmodule

bind light_to_brightness_slew ltbs_checker u_ltbs_checker (.*);

@@ tb/tb_light_to_brightness_slew.sv @@
// self-checking testbench for light_to_brightness_slew: drives timestamp and
// light-sample words, predicts updated/target/brightness and checks every result
// depends on ltbs_pkg and the light_to_brightness_slew rtl
`timescale 1ns / 100ps

module tb_light_to_brightness_slew;
    import ltbs_pkg::*;

    // cycles with no accepted word, no result word and no register write
    localparam int QUIET_LIMIT = 4000;
    // pause at the end so a stray extra result word still gets caught
    localparam int END_SETTLE  = 40;

    typedef struct packed {
        logic [TIME_W-1:0]   ts;
        logic [SAMPLE_W-1:0] sample;
        logic                ready;
    } t_light_word;

    typedef struct packed {
        logic               updated;
        logic [LEVEL_W-1:0] target;
        logic [LEVEL_W-1:0] bright;
    } t_light_result;

    // dut ports
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic [TIME_W-1:0]   i_timestamp    = '0;
    logic [SAMPLE_W-1:0] i_sample       = '0;
    logic                i_sample_ready = 1'b0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic                o_updated;
    logic [LEVEL_W-1:0]  o_target_level;
    logic [LEVEL_W-1:0]  o_brightness;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // register mirror, starts at the reset defaults
    logic [SAMPLE_W-1:0] day_lvl   = DAY_RESET;
    logic [SAMPLE_W-1:0] room_lvl  = ROOM_RESET;
    logic [SAMPLE_W-1:0] night_lvl = NIGHT_RESET;
    logic [TIME_W-1:0]   intv      = INTV_RESET;

    // predicted block state, all cleared by reset
    logic [TIME_W-1:0]   last_upd   = '0;
    logic [LEVEL_W-1:0]  target_now = '0;
    logic [LEVEL_W-1:0]  bright_now = '0;

    // update time as the stimulus generator sees it, lets it aim at due updates
    logic [TIME_W-1:0]   gen_last = '0;

    t_light_word   pending_words[$];
    t_light_result expected_results[$];
    t_light_word   next_word;

    int  queued_count = 0;
    int  taken_count  = 0;
    int  err_count    = 0;
    int  quiet_cycles = 0;
    int  idle_pct     = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    logic word_taken  = 1'b0;

    light_to_brightness_slew i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_timestamp    (i_timestamp),
        .i_sample       (i_sample),
        .i_sample_ready (i_sample_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_updated      (o_updated),
        .o_target_level (o_target_level),
        .o_brightness   (o_brightness),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // piecewise-linear light to level map; branch order decides misordered levels
    function automatic logic [LEVEL_W-1:0] level_for_sample(logic [SAMPLE_W-1:0] s);
        int half;
        int si;
        int di;
        int ri;
        int ni;
        int lvl;
        half = int'(MAX_LEVEL) / 2;
        si = s;
        di = day_lvl;
        ri = room_lvl;
        ni = night_lvl;
        if (si > di) begin
            lvl = int'(MAX_LEVEL);
        end else if (si > ri) begin
            lvl = half + (half * (si - ri)) / (di - ri);
        end else if (si > ni) begin
            lvl = (half * (si - ni)) / (ri - ni);
        end else if (si > ni / 2) begin
            lvl = 0;
        end else begin
            // sample too dark to be real, sensor taken as broken
            lvl = int'(MAX_LEVEL);
        end
        return LEVEL_W'(lvl);
    endfunction

    // one accepted word: elapsed test with 16-bit wrap, then slew by one step
    function automatic t_light_result apply_light_word(t_light_word w);
        t_light_result r;
        logic [TIME_W-1:0] elapsed;
        elapsed = w.ts - last_upd;
        r.updated = 1'b0;
        if (w.ready && elapsed >= intv) begin
            r.updated = 1'b1;
            last_upd = last_upd + intv;
            target_now = level_for_sample(w.sample);
            if (target_now > bright_now) begin
                bright_now = bright_now + 1'b1;
            end else if (target_now < bright_now) begin
                bright_now = bright_now - 1'b1;
            end
        end
        r.target = target_now;
        r.bright = bright_now;
        return r;
    endfunction

    task automatic flag_error(string what, int want, int got);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // queue one word and keep the generator's view of the update time in step
    task automatic push_word(logic [TIME_W-1:0] ts, logic [SAMPLE_W-1:0] s, logic rdy);
        t_light_word w;
        logic [TIME_W-1:0] elapsed;
        w.ts = ts;
        w.sample = s;
        w.ready = rdy;
        elapsed = ts - gen_last;
        if (rdy && elapsed >= intv) begin
            gen_last = gen_last + intv;
        end
        pending_words.push_back(w);
        queued_count++;
    endtask

    // two thirds of the samples sit at or next to a threshold, the rest anywhere
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int base;
        case ($urandom_range(0, 5))
            0: base = day_lvl;
            1: base = room_lvl;
            2: base = night_lvl;
            3: base = night_lvl / 2;
            default: return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
        endcase
        return SAMPLE_W'(base + $urandom_range(0, 2) - 1);
    endfunction

    // mostly words that land on or just past the next due time, some early
    // ones, some late ones, and a tenth with any timestamp at all
    task automatic queue_random_words(int count);
        int roll;
        logic [TIME_W-1:0] delta;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                delta = intv + TIME_W'($urandom_range(0, 3));
            end else if (roll < 75) begin
                delta = (intv > 1) ? TIME_W'($urandom_range(0, intv - 1)) : '0;
            end else if (roll < 90) begin
                delta = intv + TIME_W'($urandom_range(0, 500));
            end else begin
                delta = TIME_W'($urandom());
            end
            push_word(gen_last + delta, pick_sample(), $urandom_range(0, 9) != 0);
        end
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DAY:   day_lvl   = value[SAMPLE_W-1:0];
            REG_ROOM:  room_lvl  = value[SAMPLE_W-1:0];
            REG_NIGHT: night_lvl = value[SAMPLE_W-1:0];
            REG_INTV:  intv      = value[TIME_W-1:0];
            default: ;
        endcase
    endtask

    // every word taken and every result back; one result per word, so idle
    task automatic wait_drained();
        while (taken_count != queued_count || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // the sender holds off here until the block is empty, then reprograms it, queues words and waits for them to drain
    task automatic run_phase(int day, int room, int night, int interval, int pct,
                             int count);
        wait_drained();
        write_reg(REG_DAY, day);
        write_reg(REG_ROOM, room);
        write_reg(REG_NIGHT, night);
        write_reg(REG_INTV, interval);
        gen_last = last_upd;
        idle_pct = pct;
        queue_random_words(count);
        wait_drained();
    endtask

    // driver: new inputs at the falling edge, word held until taken
    always @(negedge i_clk) begin
        if (!i_valid || word_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_valid <= 1'b0;
            end else if (i_rst_n && pending_words.size() > 0) begin
                next_word = pending_words.pop_front();
                i_timestamp    <= next_word.ts;
                i_sample       <= next_word.sample;
                i_sample_ready <= next_word.ready;
                i_valid        <= 1'b1;
                // idle burst after this word is taken
                if ($urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
        // result side back-pressure in bursts
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (i_rst_n && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 12);
            end
        end
    end

    // monitor: checks result words first, then feeds taken words to the predictor
    always @(posedge i_clk) begin
        t_light_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                flag_error("unexpected result word, brightness", -1, o_brightness);
            end else begin
                want = expected_results.pop_front();
                if (o_updated !== want.updated) begin
                    flag_error("updated", want.updated, o_updated);
                end
                if (o_target_level !== want.target) begin
                    flag_error("target_level", want.target, o_target_level);
                end
                if (o_brightness !== want.bright) begin
                    flag_error("brightness", want.bright, o_brightness);
                end
            end
        end
        word_taken = i_rst_n && i_valid && !o_stall;
        if (word_taken) begin
            expected_results.push_back(apply_light_word({i_timestamp, i_sample,
                                                         i_sample_ready}));
            taken_count++;
        end
    end

    // watchdog on lack of progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_light_to_brightness_slew failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on the reset settings (day 800, room 400, night 100,
        // interval 100)
        idle_pct = 15;
        push_word(16'd0, 10'd500, 1'b1);        // too early, no update
        push_word(16'd100, 10'd1023, 1'b1);     // first update, above day level
        push_word(16'd150, 10'd700, 1'b1);      // interval not yet passed
        push_word(16'd250, 10'd900, 1'b0);      // interval passed but sample not ready
        push_word(16'd250, 10'd0, 1'b1);        // dark floor, sensor taken as broken
        push_word(16'd300, 10'd800, 1'b1);      // exactly day level
        push_word(16'd400, 10'd801, 1'b1);      // just above day level
        push_word(16'd500, 10'd401, 1'b1);      // just above room level
        push_word(16'd600, 10'd400, 1'b1);      // exactly room level
        push_word(16'd700, 10'd101, 1'b1);      // just above night level
        push_word(16'd800, 10'd100, 1'b1);      // exactly night level
        push_word(16'd900, 10'd51, 1'b1);       // just above half night level
        push_word(16'd1000, 10'd50, 1'b1);      // exactly half night level
        push_word(16'hFFFF, 10'h3FF, 1'b0);     // all-ones fields, not ready
        push_word(16'hFFFF, 10'h3FF, 1'b1);     // all-ones fields, ready
        push_word(16'd0, 10'd512, 1'b1);        // timestamp wraps past zero

        // extremes and oddities of the settings
        run_phase(1023, 512, 2, 1, 40, 150);        // shortest nonzero interval
        run_phase(0, 1023, 1023, 65535, 15, 120);   // longest interval, levels reversed
        run_phase(600, 300, 200, 0, 40, 120);       // interval zero always passes
        run_phase(1023, 1023, 1023, 7, 0, 100);     // all levels at the top
        run_phase(0, 0, 0, 1000, 15, 100);          // all levels at zero
        run_phase(1023, 0, 1023, 50, 40, 100);      // night level above room level

        // random well-ordered settings
        repeat (6) begin
            int night;
            int room;
            int day;
            int pct;
            night = $urandom_range(0, 1023);
            room  = $urandom_range(night, 1023);
            day   = $urandom_range(room, 1023);
            case ($urandom_range(0, 2))
                0: pct = 0;
                1: pct = 15;
                default: pct = 40;
            endcase
            run_phase(day, room, night, $urandom_range(1, 300), pct, 100);
        end

        // closing stretch back on the defaults without any idling
        run_phase(800, 400, 100, 100, 0, 150);

        repeat (END_SETTLE) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_light_to_brightness_slew passed");
        end else begin
            $display("tb_light_to_brightness_slew failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ltbs_pkg.sv
rtl/light_to_brightness_slew.sv
rtl/ltbs_checker.sv
tb/tb_light_to_brightness_slew.sv
